// ===== src/nau_pkg.sv =====
// ----------------------------------------------------------------------------
// nau_pkg
// Shared types and register indexes of the neuron activation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nau_pkg;

   typedef enum logic [1:0] {
      MODE_IDENTITY,
      MODE_SIGMOID,
      MODE_LINEAR,
      MODE_BINARY
   } mode_type;

   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_X     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_X     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_Y     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_Y     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_CUT_LEVEL = 3'd6;

   // per item flags carried alongside the divider chain
   typedef struct packed {
      logic sig_sat;   // sigmoid input beyond the saturation point
      logic x_neg;     // scaled sigmoid input is negative
      logic lin_neg;   // linear quotient is negative
      logic lin_ovf;   // linear quotient too large for the chain
   } flags_type;

endpackage

`default_nettype wire

// ===== src/nau_front.sv =====
// ----------------------------------------------------------------------------
// nau_front
// Two stage front end: products, then sigmoid scaling and divider set-up.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_front #(
   parameter int W   = 32,
   parameter int F   = 16,
   parameter int NQ  = 33,
   parameter int SDW = 25,
   parameter int LDW = 33
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [W-1:0]        in_s,
   input  wire logic [W-1:0]        gain,
   input  wire logic [W-1:0]        min_x,
   input  wire logic [W:0]          dy,
   input  wire logic [LDW-1:0]      lin_div,
   output logic                     out_valid,
   output logic [W-1:0]             out_s,
   output nau_pkg::flags_type       out_flags,
   output logic [SDW-1:0]           out_sden,
   output logic [SDW-1:0]           out_srem,
   output logic [NQ-1:0]            out_snq,
   output logic [LDW-1:0]           out_lrem,
   output logic [NQ-1:0]            out_lnq
);
   import nau_pkg::*;

   localparam int MW = 2 * W;
   localparam int NS = NQ + SDW;
   localparam int NL = NQ + LDW;
   localparam int X0_INT = (20 << F) / 3;
   localparam logic [MW-1:0] X0   = MW'(X0_INT);
   localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

   // stage a: magnitudes and products
   logic [W:0]    dx;
   logic [W-1:0]  s_mag, g_mag, dx_mag, dy_mag;
   logic          a_valid_ff;
   logic [W-1:0]  a_s_ff;
   logic [MW-1:0] a_ps_ff, a_pl_ff;
   logic          a_sneg_ff, a_lneg_ff;

   assign dx     = {in_s[W-1], in_s} - {min_x[W-1], min_x};
   assign s_mag  = in_s[W-1] ? (~in_s + 1'b1) : in_s;
   assign g_mag  = gain[W-1] ? (~gain + 1'b1) : gain;
   assign dx_mag = dx[W] ? W'(~dx + 1'b1) : dx[W-1:0];
   assign dy_mag = dy[W] ? W'(~dy + 1'b1) : dy[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
      if (en) begin
         a_s_ff    <= in_s;
         a_ps_ff   <= MW'(s_mag) * MW'(g_mag);
         a_pl_ff   <= MW'(dx_mag) * MW'(dy_mag);
         a_sneg_ff <= in_s[W-1] ^ gain[W-1];
         a_lneg_ff <= dx[W] ^ dy[W];
      end
   end

   // stage b: saturate scaled input, build dividends and divisors
   logic [MW-1:0]  m2, ax;
   logic [F+2:0]   ax_n;
   logic [NS-1:0]  num;
   logic [NL-1:0]  pl_ext;
   logic [SDW-1:0] sden_in;
   logic [LDW-1:0] lrem_in;
   flags_type      flags_in;

   always_comb begin
      m2 = a_ps_ff >> F;
      if (a_sneg_ff) begin
         ax = (m2 > HALF) ? HALF : m2;
      end else begin
         ax = (m2 > HALF - 1'b1) ? HALF - 1'b1 : m2;
      end
      ax_n    = ax[F+2:0];
      num     = (NS'(ax_n) * NS'(23)) << F;
      sden_in = SDW'(40) * ((SDW'(1) << F) + SDW'(ax_n));
      pl_ext  = NL'(a_pl_ff);
      lrem_in = pl_ext[NL-1:NQ];
      flags_in.sig_sat = (ax >= X0);
      flags_in.x_neg   = a_sneg_ff;
      flags_in.lin_neg = a_lneg_ff;
      flags_in.lin_ovf = (lrem_in >= lin_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= a_valid_ff;
      end
      if (en) begin
         out_s     <= a_s_ff;
         out_flags <= flags_in;
         out_sden  <= sden_in;
         out_srem  <= num[NS-1:NQ];
         out_snq   <= num[NQ-1:0];
         out_lrem  <= lrem_in;
         out_lnq   <= pl_ext[NQ-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== src/nau_div_cell.sv =====
// ----------------------------------------------------------------------------
// nau_div_cell
// One restoring division step for the sigmoid and the linear quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_div_cell #(
   parameter int W   = 32,
   parameter int NQ  = 33,
   parameter int SDW = 25,
   parameter int LDW = 33
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic [LDW-1:0]      lin_div,
   input  wire logic                in_valid,
   input  wire logic [W-1:0]        in_s,
   input  wire nau_pkg::flags_type  in_flags,
   input  wire logic [SDW-1:0]      in_sden,
   input  wire logic [SDW-1:0]      in_srem,
   input  wire logic [NQ-1:0]       in_snq,
   input  wire logic [LDW-1:0]      in_lrem,
   input  wire logic [NQ-1:0]       in_lnq,
   output logic                     out_valid,
   output logic [W-1:0]             out_s,
   output nau_pkg::flags_type       out_flags,
   output logic [SDW-1:0]           out_sden,
   output logic [SDW-1:0]           out_srem,
   output logic [NQ-1:0]            out_snq,
   output logic [LDW-1:0]           out_lrem,
   output logic [NQ-1:0]            out_lnq
);
   import nau_pkg::*;

   logic [SDW:0]   s_try, s_diff;
   logic [LDW:0]   l_try, l_diff;
   logic           s_ge, l_ge;
   logic [SDW-1:0] srem_in;
   logic [LDW-1:0] lrem_in;

   // shift in the next dividend bit, subtract where it fits
   always_comb begin
      s_try   = {in_srem, in_snq[NQ-1]};
      s_diff  = s_try - {1'b0, in_sden};
      s_ge    = (s_try >= {1'b0, in_sden});
      srem_in = s_ge ? s_diff[SDW-1:0] : s_try[SDW-1:0];
      l_try   = {in_lrem, in_lnq[NQ-1]};
      l_diff  = l_try - {1'b0, lin_div};
      l_ge    = (l_try >= {1'b0, lin_div});
      lrem_in = l_ge ? l_diff[LDW-1:0] : l_try[LDW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= in_valid;
      end
      if (en) begin
         out_s     <= in_s;
         out_flags <= in_flags;
         out_sden  <= in_sden;
         out_srem  <= srem_in;
         out_snq   <= {in_snq[NQ-2:0], s_ge};
         out_lrem  <= lrem_in;
         out_lnq   <= {in_lnq[NQ-2:0], l_ge};
      end
   end

endmodule

`default_nettype wire

// ===== src/nau_back.sv =====
// ----------------------------------------------------------------------------
// nau_back
// Result selection by mode and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nau_back #(
   parameter int W  = 32,
   parameter int F  = 16,
   parameter int NQ = 33
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire nau_pkg::mode_type   mode,
   input  wire logic [W-1:0]        min_y,
   input  wire logic [W-1:0]        max_y,
   input  wire logic [W-1:0]        cut_level,
   input  wire logic [W:0]          dy,
   input  wire logic                lin_err,
   input  wire logic                in_valid,
   input  wire logic [W-1:0]        in_s,
   input  wire nau_pkg::flags_type  in_flags,
   input  wire logic [NQ-1:0]       in_squot,
   input  wire logic [NQ-1:0]       in_lquot,
   output logic                     out_valid,
   output logic [W-1:0]             out_act,
   output logic                     out_err
);
   import nau_pkg::*;

   localparam logic [W-1:0] ONE_W  = W'(1) << F;
   localparam logic [W-1:0] HALF_W = W'(1) << (F - 1);

   logic [W-1:0] sig_val, lin_val, act_in;
   logic         q_gt, err_in;

   always_comb begin
      if (in_flags.sig_sat) begin
         sig_val = in_flags.x_neg ? '0 : ONE_W;
      end else if (in_flags.x_neg) begin
         sig_val = HALF_W - in_squot[W-1:0];
      end else begin
         sig_val = HALF_W + in_squot[W-1:0];
      end

      q_gt = dy[W] | (in_lquot > NQ'(dy));
      if (lin_err) begin
         lin_val = min_y;
      end else if (in_flags.lin_ovf) begin
         lin_val = in_flags.lin_neg ? min_y : max_y;
      end else if (in_flags.lin_neg) begin
         // a zero quotient still counts against a reversed output range
         lin_val = ((in_lquot == '0) && dy[W]) ? max_y : min_y;
      end else begin
         lin_val = q_gt ? max_y : min_y + in_lquot[W-1:0];
      end

      err_in = 1'b0;
      case (mode)
         MODE_IDENTITY: act_in = in_s;
         MODE_SIGMOID:  act_in = sig_val;
         MODE_LINEAR: begin
            act_in = lin_val;
            err_in = lin_err;
         end
         MODE_BINARY:   act_in = ($signed(in_s) > $signed(cut_level)) ? ONE_W : '0;
         default:       act_in = in_s;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= in_valid;
      end
      if (en) begin
         out_act <= act_in;
         out_err <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/neuron_activation_unit_top.sv =====
// ----------------------------------------------------------------------------
// neuron_activation_unit_top
// Streaming neuron activation: identity, rational sigmoid, clamped linear
// map or binary threshold, selected by the mode register.
//
// req_* carries one signed fixed-point neuron sum per item, rsp_* one
// activation per item with the range error flag in rsp_tuser. csr_* writes
// the registers; write them only while no item is in flight.
// The pipe holds two front stages, one cell per quotient bit in the divider
// chain, and the output register. One item is accepted every cycle while
// the output is not stalled.
// The whole pipe advances together; while rsp_tvalid is high and rsp_tready
// low, req_tready is low and every stage holds its item.
// Reset empties the pipe and loads the register defaults (sigmoid mode,
// gain 1.0, input and output range 0 to 1.0, threshold 0).
// ----------------------------------------------------------------------------
`default_nettype none

module neuron_activation_unit_top #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,  // neuron_sum
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]           rsp_tdata,  // activation
   output logic                                      rsp_tuser,  // range_error
   input  wire logic                                 csr_wen,
   input  wire logic [nau_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [DATA_WIDTH-1:0]                csr_wdata
);
   import nau_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int TDW = ((W + 7) / 8) * 8;
   localparam int NQ  = (W + 1 > F) ? W + 1 : F;
   localparam int SDW = F + 9;
   localparam int LDW = W + 1;
   localparam logic [W-1:0] ONE_W = W'(1) << F;

   mode_type     mode_ff;
   logic [W-1:0] gain_ff, min_x_ff, max_x_ff, min_y_ff, max_y_ff, cut_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SIGMOID;
         gain_ff  <= ONE_W;
         min_x_ff <= '0;
         max_x_ff <= ONE_W;
         min_y_ff <= '0;
         max_y_ff <= ONE_W;
         cut_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_MODE:      mode_ff  <= mode_type'(csr_wdata[1:0]);
            CSR_GAIN:      gain_ff  <= csr_wdata;
            CSR_MIN_X:     min_x_ff <= csr_wdata;
            CSR_MAX_X:     max_x_ff <= csr_wdata;
            CSR_MIN_Y:     min_y_ff <= csr_wdata;
            CSR_MAX_Y:     max_y_ff <= csr_wdata;
            CSR_CUT_LEVEL: cut_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // register derived values; the user keeps them constant while items are in flight, the block does not enforce it
   logic [W:0] dy, dspan;
   logic       lin_err;
   assign dy      = {max_y_ff[W-1], max_y_ff} - {min_y_ff[W-1], min_y_ff};
   assign dspan   = {max_x_ff[W-1], max_x_ff} - {min_x_ff[W-1], min_x_ff};
   assign lin_err = dspan[W] | (dspan == '0);

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic           c_valid [0:NQ];
   logic [W-1:0]   c_s     [0:NQ];
   flags_type      c_flags [0:NQ];
   logic [SDW-1:0] c_sden  [0:NQ];
   logic [SDW-1:0] c_srem  [0:NQ];
   logic [NQ-1:0]  c_snq   [0:NQ];
   logic [LDW-1:0] c_lrem  [0:NQ];
   logic [NQ-1:0]  c_lnq   [0:NQ];

   nau_front #(.W(W), .F(F), .NQ(NQ), .SDW(SDW), .LDW(LDW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_s      (req_tdata[W-1:0]),
      .gain      (gain_ff),
      .min_x     (min_x_ff),
      .dy        (dy),
      .lin_div   (dspan),
      .out_valid (c_valid[0]),
      .out_s     (c_s[0]),
      .out_flags (c_flags[0]),
      .out_sden  (c_sden[0]),
      .out_srem  (c_srem[0]),
      .out_snq   (c_snq[0]),
      .out_lrem  (c_lrem[0]),
      .out_lnq   (c_lnq[0])
   );

   for (genvar i = 0; i < NQ; i++) begin : g_cell
      nau_div_cell #(.W(W), .NQ(NQ), .SDW(SDW), .LDW(LDW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .lin_div   (dspan),
         .in_valid  (c_valid[i]),
         .in_s      (c_s[i]),
         .in_flags  (c_flags[i]),
         .in_sden   (c_sden[i]),
         .in_srem   (c_srem[i]),
         .in_snq    (c_snq[i]),
         .in_lrem   (c_lrem[i]),
         .in_lnq    (c_lnq[i]),
         .out_valid (c_valid[i+1]),
         .out_s     (c_s[i+1]),
         .out_flags (c_flags[i+1]),
         .out_sden  (c_sden[i+1]),
         .out_srem  (c_srem[i+1]),
         .out_snq   (c_snq[i+1]),
         .out_lrem  (c_lrem[i+1]),
         .out_lnq   (c_lnq[i+1])
      );
   end

   logic [W-1:0] act;

   nau_back #(.W(W), .F(F), .NQ(NQ)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .mode      (mode_ff),
      .min_y     (min_y_ff),
      .max_y     (max_y_ff),
      .cut_level (cut_ff),
      .dy        (dy),
      .lin_err   (lin_err),
      .in_valid  (c_valid[NQ]),
      .in_s      (c_s[NQ]),
      .in_flags  (c_flags[NQ]),
      .in_squot  (c_snq[NQ]),
      .in_lquot  (c_lnq[NQ]),
      .out_valid (rsp_tvalid),
      .out_act   (act),
      .out_err   (rsp_tuser)
   );

   assign rsp_tdata = TDW'(act);

endmodule

`default_nettype wire

// ===== bench/activation_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// activation_monitor
// Watches the register, sum and activation ports of the neuron activation
// unit, works out the expected activation and range flag for every accepted
// sum, and compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module activation_monitor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // neuron_sum
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // activation
   input  wire logic        rsp_tuser,   // range_error
   input  wire logic        csr_wen,
   input  wire logic [nau_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [31:0] csr_wdata,
   output int               mismatches,
   output int               outstanding
);
   import nau_pkg::*;

   localparam longint ONE_Q = 64'sd65536;
   localparam longint SAT_X = (64'sd20 <<< 16) / 3;
   localparam longint POS_MAX = 64'sd2147483647;

   typedef struct {
      logic [31:0] activation;
      logic        range_error;
   } activation_type;

   mode_type           act_mode;
   logic signed [31:0] act_gain, lo_x, hi_x, lo_y, hi_y, cut;
   activation_type     pending_activations[$];

   function automatic activation_type compute_activation(logic signed [31:0] sum);
      activation_type res;
      longint s, p, m, x, ax, t, dx, dy, d, q;
      logic [127:0] wide_prod, wide_q;
      s = longint'(sum);
      res.range_error = 1'b0;
      case (act_mode)
         MODE_IDENTITY: res.activation = sum;
         MODE_SIGMOID: begin
            p = s * longint'(act_gain);
            m = (p < 0 ? -p : p) >>> 16;
            if (p < 0) begin
               if (m > POS_MAX + 1) m = POS_MAX + 1;
               x = -m;
            end else begin
               x = m > POS_MAX ? POS_MAX : m;
            end
            if (x <= -SAT_X) res.activation = '0;
            else if (x >= SAT_X) res.activation = 32'(ONE_Q);
            else begin
               ax = x < 0 ? -x : x;
               t = (23 * ax * ONE_Q) / (40 * (ONE_Q + ax));
               res.activation = 32'(ONE_Q / 2 + (x < 0 ? -t : t));
            end
         end
         MODE_LINEAR: begin
            dx = s - longint'(lo_x);
            dy = longint'(hi_y) - longint'(lo_y);
            d  = longint'(hi_x) - longint'(lo_x);
            if (d <= 0) begin
               res.activation  = lo_y;
               res.range_error = 1'b1;
            end else begin
               wide_prod = 128'(dx < 0 ? -dx : dx) * 128'(dy < 0 ? -dy : dy);
               wide_q = wide_prod / 128'(d);
               if (wide_q > (128'd1 << 62)) wide_q = 128'd1 << 62;
               q = longint'(wide_q[63:0]);
               if ((dx < 0) != (dy < 0)) q = -q;
               if (q < 0) res.activation = lo_y;
               else if (q > dy) res.activation = hi_y;
               else res.activation = 32'(longint'(lo_y) + q);
            end
         end
         default: res.activation = sum > cut ? 32'(ONE_Q) : '0;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      activation_type exp_act;
      int errs;
      errs = 0;
      if (reset) begin
         act_mode <= MODE_SIGMOID;
         act_gain <= 32'sd65536;
         lo_x <= '0;
         hi_x <= 32'sd65536;
         lo_y <= '0;
         hi_y <= 32'sd65536;
         cut  <= '0;
         pending_activations.delete();
         mismatches <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_activations.size() == 0) begin
               $error("activation with no sum waiting: %h", rsp_tdata);
               errs++;
            end else begin
               exp_act = pending_activations.pop_front();
               if (rsp_tdata !== exp_act.activation) begin
                  $error("activation: expected %h, got %h", exp_act.activation, rsp_tdata);
                  errs++;
               end
               if (rsp_tuser !== exp_act.range_error) begin
                  $error("range_error: expected %b, got %b", exp_act.range_error,
                         rsp_tuser);
                  errs++;
               end
            end
         end
         if (errs != 0)
            mismatches <= mismatches + errs;
         // results are computed with the registers in force when the item is taken
         if (req_tvalid && req_tready)
            pending_activations.push_back(compute_activation(req_tdata));
         if (csr_wen) begin
            case (csr_addr)
               CSR_MODE:      act_mode <= mode_type'(csr_wdata[1:0]);
               CSR_GAIN:      act_gain <= csr_wdata;
               CSR_MIN_X:     lo_x <= csr_wdata;
               CSR_MAX_X:     hi_x <= csr_wdata;
               CSR_MIN_Y:     lo_y <= csr_wdata;
               CSR_MAX_Y:     hi_y <= csr_wdata;
               CSR_CUT_LEVEL: cut <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign outstanding = pending_activations.size();

endmodule

`default_nettype wire

// ===== bench/tb_neuron_activation_unit_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neuron_activation_unit_top
// Drives neuron sums through the activation unit under a series of register
// settings (every mode, register extremes, empty and reversed linear ranges)
// with random stalls on both sides; the monitor checks every activation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_neuron_activation_unit_top;
   import nau_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = 45;
   localparam int TOTAL_ITEMS = 550;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // neuron_sum
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // activation
   logic        rsp_tuser;         // range_error
   logic        csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   int  mismatches, outstanding, sums_sent;
   bit  quiet, long_hold;
   logic [31:0] corner_sums[14] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
      32'h1, 32'h0001_0000, 32'hffff_0000, 32'd436906, 32'd436907, -32'sd436906,
      -32'sd436907, 32'h0000_8000, 32'h5555_aaaa, 32'haaaa_5555};

   always #5 clock = ~clock;

   neuron_activation_unit_top u_top (.*);

   activation_monitor u_monitor (.*);

   task automatic push_sum(input logic [31:0] v);
      req_tdata  <= v;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sums_sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      csr_wen   <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(negedge clock);
   endtask

   // drain, then load a full register set
   task automatic load_settings(input logic [31:0] m, g, lx, hx, ly, hy, c);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
      write_csr(CSR_MODE, m);
      write_csr(CSR_GAIN, g);
      write_csr(CSR_MIN_X, lx);
      write_csr(CSR_MAX_X, hx);
      write_csr(CSR_MIN_Y, ly);
      write_csr(CSR_MAX_Y, hy);
      write_csr(CSR_CUT_LEVEL, c);
      write_csr(CSR_SPARE, $urandom);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_sum();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1_048_576)) - 524288);
         2: return corner_sums[$urandom_range(0, 13)];
         default: return 32'($signed($urandom_range(0, 262144)) - 131072);
      endcase
   endfunction

   function automatic logic [31:0] pick_reg();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1_048_576)) - 524288);
         2: return corner_sums[$urandom_range(0, 3)];
         default: return 32'($signed($urandom_range(0, 8192)) - 4096) <<< 8;
      endcase
   endfunction

   initial begin
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("neuron_activation_unit_top verification failed");
      $finish;
   end

   initial begin
      logic [31:0] lx, hx, ly, hy;
      int phase;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: sigmoid with unit gain
      foreach (corner_sums[i]) push_sum(corner_sums[i]);
      load_settings(MODE_IDENTITY, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) push_sum(corner_sums[i]);
      // full-scale linear range, then an empty one
      load_settings(MODE_LINEAR, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 0);
      for (int i = 0; i < 4; i++) push_sum(corner_sums[i]);
      load_settings(MODE_LINEAR, 0, 32'h10000, 32'h10000, 32'h1234, 32'h0, 0);
      push_sum(32'h10000);
      load_settings(MODE_BINARY, 0, 0, 0, 0, 0, 32'h7fff_ffff);
      push_sum(32'h7fff_ffff);
      load_settings(MODE_BINARY, 0, 0, 0, 0, 0, 32'h8000_0000);
      push_sum(32'h8000_0000);

      phase = 0;
      while (sums_sent < TOTAL_ITEMS) begin
         lx = pick_reg();
         hx = pick_reg();
         ly = pick_reg();
         hy = pick_reg();
         // mostly ordered ranges so the map itself gets exercised
         if ($urandom_range(0, 3) != 0 && $signed(hx) < $signed(lx)) {lx, hx} = {hx, lx};
         if ($urandom_range(0, 3) != 0 && $signed(hy) < $signed(ly)) {ly, hy} = {hy, ly};
         load_settings(phase < 4 ? phase : $urandom_range(0, 3),
                       phase == 5 ? 32'h8000_0000 : phase == 6 ? 32'h7fff_ffff : pick_reg(),
                       lx, hx, ly, hy, pick_reg());
         if (phase == 3) long_hold = 1'b1;
         if (sums_sent > 450) quiet = 1'b1;
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 2) == 0 && $signed(hx) > $signed(lx))
               push_sum(32'($signed(lx) + $signed(32'($urandom_range(0, 65536)))
                            * ($signed(hx) - $signed(lx)) / 65536));
            else
               push_sum(pick_sum());
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
      if (mismatches == 0)
         $display("neuron_activation_unit_top verification clean");
      else
         $display("neuron_activation_unit_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/nau_pkg.sv
src/nau_front.sv
src/nau_div_cell.sv
src/nau_back.sv
src/neuron_activation_unit_top.sv
bench/activation_monitor.sv
bench/tb_neuron_activation_unit_top.sv
